// ===== rtl/rtri_pkg.sv =====
// shared types and constants for the triangle rasterizer
package rtri_pkg;

  localparam int CRD_W   = 16;
  localparam int ZW      = 24;
  localparam int COLOR_W = 24;
  localparam int LIGHT_W = 9;
  localparam int CNT_W   = 21;
  localparam int DBL_W   = 17;
  localparam int DIF_W   = 18;
  localparam int AREA_W  = 36;
  localparam int HALF_W  = 18;
  localparam int PIX_W   = 12;
  localparam int ADDR_W  = 24;
  localparam int CLIP_W  = 10;

  localparam logic [ZW-1:0]     DEPTH_MIN = 24'h800000;
  localparam logic [CLIP_W-1:0] CLIP_MAX  = 10'd1023;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_RIGHT  = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CLIP_W-1:0] left;
    logic [CLIP_W-1:0] top;
    logic [CLIP_W-1:0] right;
    logic [CLIP_W-1:0] bottom;
  } clip_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic                     degen;
    logic                     empty;
    logic                     neg;
    logic                     rd_ok;
    logic signed [DBL_W-1:0]  ax;
    logic signed [DBL_W-1:0]  ay;
    logic signed [DBL_W-1:0]  bx;
    logic signed [DBL_W-1:0]  by;
    logic signed [DBL_W-1:0]  cx;
    logic signed [DBL_W-1:0]  cy;
    logic signed [ZW-1:0]     az;
    logic signed [ZW-1:0]     bz;
    logic signed [ZW-1:0]     cz;
    logic [COLOR_W-1:0]       rgb;
    logic [AREA_W-1:0]        area;
    logic [PIX_W-1:0]         left;
    logic [PIX_W-1:0]         right;
    logic [PIX_W-1:0]         top;
    logic [PIX_W-1:0]         bottom;
    logic [ADDR_W-1:0]        addr;
  } job_t;

endpackage

// ===== rtl/rtri_if.sv =====
// request and result channel interfaces
interface rtri_req_if
  import rtri_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic signed [CRD_W-1:0] x0;
  logic signed [CRD_W-1:0] y0;
  logic signed [ZW-1:0]    z0;
  logic signed [CRD_W-1:0] x1;
  logic signed [CRD_W-1:0] y1;
  logic signed [ZW-1:0]    z1;
  logic signed [CRD_W-1:0] x2;
  logic signed [CRD_W-1:0] y2;
  logic signed [ZW-1:0]    z2;
  logic [COLOR_W-1:0]      color;
  logic [LIGHT_W-1:0]      light;

  modport source (output valid, command, x0, y0, z0, x1, y1, z1, x2, y2, z2, color, light,
                  input ready);
  modport sink (input valid, command, x0, y0, z0, x1, y1, z1, x2, y2, z2, color, light,
                output ready);
endinterface

interface rtri_rsp_if
  import rtri_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [COLOR_W-1:0]   read_color;
  logic signed [ZW-1:0] read_depth;
  logic [CNT_W-1:0]     pixels_written;
  logic                 degenerate;

  modport source (output valid, read_color, read_depth, pixels_written, degenerate,
                  input ready);
  modport sink (input valid, read_color, read_depth, pixels_written, degenerate,
                output ready);
endinterface

// ===== rtl/rtri_ram.sv =====
// generic single-port-write, registered-read ram
module rtri_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/rtri_front.sv =====
// front end: takes requests, computes area, scan box, lit color and read address
module rtri_front
  import rtri_pkg::*;
#(
  parameter int FB_WIDTH      = 1024,
  parameter int FB_HEIGHT     = 1024,
  parameter int SUBPIXEL_BITS = 4
) (
  input  logic   clk,
  input  logic   rst,
  rtri_req_if.sink req,
  input  clip_t  clip,
  input  logic   full,
  output logic   push,
  output job_t   push_job
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  localparam int SA_W = 2 * DIF_W + 1;
  localparam int CP_W = 8 + LIGHT_W;
  localparam logic signed [DIF_W-1:0] CEIL_ADD = DIF_W'((1 << SUBPIXEL_BITS) - 1);
  localparam logic signed [DIF_W-1:0] X_MAX    = DIF_W'(FB_WIDTH - 1);
  localparam logic signed [DIF_W-1:0] Y_MAX    = DIF_W'(FB_HEIGHT - 1);

  fstate_t state;
  logic [1:0]              cmd;
  logic signed [CRD_W-1:0] x0, y0, x1, y1, x2, y2;
  logic signed [ZW-1:0]    z0, z1, z2;
  logic [COLOR_W-1:0]      color;
  logic [LIGHT_W-1:0]      light;
  logic signed [2*DIF_W-1:0] prod_a, prod_b;
  logic [CP_W-1:0]         ch_prod [3];
  logic                    rd_ok;
  logic [ADDR_W-1:0]       rd_addr;

  logic signed [DBL_W-1:0] ax, ay, bx, by, cx, cy;
  logic signed [DIF_W-1:0] dxb, dyb, dxc, dyc;
  logic signed [SA_W-1:0]  area_s, area_abs;
  logic signed [DIF_W-1:0] lo_x, hi_x, lo_y, hi_y, cl, ct, cr, cb;
  logic signed [DIF_W-1:0] l_x, r_x0, r_x, t_y, b_y0, b_y;
  logic [COLOR_W-1:0]      lit;

  function automatic logic signed [CRD_W-1:0] min3(input logic signed [CRD_W-1:0] a,
                                                   input logic signed [CRD_W-1:0] b,
                                                   input logic signed [CRD_W-1:0] c);
    logic signed [CRD_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [CRD_W-1:0] max3(input logic signed [CRD_W-1:0] a,
                                                   input logic signed [CRD_W-1:0] b,
                                                   input logic signed [CRD_W-1:0] c);
    logic signed [CRD_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [7:0] sat(input logic [CP_W-1:0] p);
    logic [CP_W:0] s;
    s = {1'b0, p} + (CP_W+1)'(128);
    return (s[CP_W:8] > (CP_W-7)'(255)) ? 8'hFF : s[15:8];
  endfunction

  assign req.ready = (state == F_IDLE);
  assign push      = (state == F_PUSH) && !full;

  assign ax = $signed({x0, 1'b0});
  assign ay = $signed({y0, 1'b0});
  assign bx = $signed({x1, 1'b0});
  assign by = $signed({y1, 1'b0});
  assign cx = $signed({x2, 1'b0});
  assign cy = $signed({y2, 1'b0});
  assign dxb = DIF_W'(bx) - DIF_W'(ax);
  assign dyb = DIF_W'(by) - DIF_W'(ay);
  assign dxc = DIF_W'(cx) - DIF_W'(ax);
  assign dyc = DIF_W'(cy) - DIF_W'(ay);

  assign area_s   = SA_W'(prod_a) - SA_W'(prod_b);
  assign area_abs = area_s[SA_W-1] ? -area_s : area_s;

  assign lo_x = DIF_W'(min3(x0, x1, x2)) >>> SUBPIXEL_BITS;
  assign hi_x = (DIF_W'(max3(x0, x1, x2)) + CEIL_ADD) >>> SUBPIXEL_BITS;
  assign lo_y = DIF_W'(min3(y0, y1, y2)) >>> SUBPIXEL_BITS;
  assign hi_y = (DIF_W'(max3(y0, y1, y2)) + CEIL_ADD) >>> SUBPIXEL_BITS;
  assign cl = $signed(DIF_W'(clip.left));
  assign ct = $signed(DIF_W'(clip.top));
  assign cr = $signed(DIF_W'(clip.right));
  assign cb = $signed(DIF_W'(clip.bottom));
  assign l_x  = (lo_x > cl) ? lo_x : cl;
  assign t_y  = (lo_y > ct) ? lo_y : ct;
  assign r_x0 = (hi_x < cr) ? hi_x : cr;
  assign r_x  = (r_x0 < X_MAX) ? r_x0 : X_MAX;
  assign b_y0 = (hi_y < cb) ? hi_y : cb;
  assign b_y  = (b_y0 < Y_MAX) ? b_y0 : Y_MAX;

  assign lit = {sat(ch_prod[2]), sat(ch_prod[1]), sat(ch_prod[0])};

  always_comb begin
    push_job        = '0;
    push_job.cmd    = cmd_t'(cmd);
    push_job.degen  = (area_s == '0);
    push_job.empty  = (l_x > r_x) || (t_y > b_y);
    push_job.neg    = area_s[SA_W-1];
    push_job.rd_ok  = rd_ok;
    push_job.ax     = ax;
    push_job.ay     = ay;
    push_job.bx     = bx;
    push_job.by     = by;
    push_job.cx     = cx;
    push_job.cy     = cy;
    push_job.az     = z0;
    push_job.bz     = z1;
    push_job.cz     = z2;
    push_job.rgb    = (cmd_t'(cmd) == CMD_CLEAR) ? color : lit;
    push_job.area   = area_abs[AREA_W-1:0];
    push_job.left   = l_x[PIX_W-1:0];
    push_job.right  = r_x[PIX_W-1:0];
    push_job.top    = t_y[PIX_W-1:0];
    push_job.bottom = b_y[PIX_W-1:0];
    push_job.addr   = rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: if (req.valid) begin
          state <= F_MUL;
        end
        F_MUL: state <= F_PUSH;
        F_PUSH: if (!full) begin
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && req.valid) begin
      cmd   <= req.command;
      x0    <= req.x0;
      y0    <= req.y0;
      z0    <= req.z0;
      x1    <= req.x1;
      y1    <= req.y1;
      z1    <= req.z1;
      x2    <= req.x2;
      y2    <= req.y2;
      z2    <= req.z2;
      color <= req.color;
      light <= req.light;
    end
    if (state == F_MUL) begin
      prod_a     <= dxc * dyb;
      prod_b     <= dyc * dxb;
      ch_prod[0] <= CP_W'(color[7:0]) * CP_W'(light);
      ch_prod[1] <= CP_W'(color[15:8]) * CP_W'(light);
      ch_prod[2] <= CP_W'(color[23:16]) * CP_W'(light);
      rd_ok      <= (x0 >= 16'sd0) && (x0 < $signed(CRD_W'(FB_WIDTH))) &&
                    (y0 >= 16'sd0) && (y0 < $signed(CRD_W'(FB_HEIGHT)));
      rd_addr    <= ADDR_W'(y0[PIX_W-1:0]) * ADDR_W'(FB_WIDTH) + ADDR_W'(x0[PIX_W-1:0]);
    end
  end
endmodule

// ===== rtl/rtri_queue.sv =====
// two-entry job queue between front and back end
module rtri_queue
  import rtri_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);
  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end
endmodule

// ===== rtl/rtri_back.sv =====
// back end: pixel scan, depth interpolation, store access and result
module rtri_back
  import rtri_pkg::*;
#(
  parameter int FB_WIDTH      = 1024,
  parameter int FB_HEIGHT     = 1024,
  parameter int SUBPIXEL_BITS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  job_t job,
  output logic job_pop,
  rtri_rsp_if.source rsp
);
  localparam int NPIX   = FB_WIDTH * FB_HEIGHT;
  localparam int AW     = $clog2(NPIX);
  localparam int SW     = PIX_W + SUBPIXEL_BITS + 2;
  localparam int DW     = ((SW > DBL_W) ? SW : DBL_W) + 1;
  localparam int PW     = DW + DIF_W;
  localparam int EW     = PW + 1;
  localparam int MW     = HALF_W + 1 + ZW;
  localparam int NUM_W  = AREA_W + ZW + 1;
  localparam int NW     = NUM_W + 1;
  localparam int RAM_W  = COLOR_W + ZW;
  localparam logic [4:0] LAST_STEP = 5'(ZW - 1);

  typedef enum logic [10:0] {
    B_IDLE  = 11'b00000000001,
    B_CLEAR = 11'b00000000010,
    B_RD    = 11'b00000000100,
    B_EDGE  = 11'b00000001000,
    B_EDGE2 = 11'b00000010000,
    B_MAC   = 11'b00000100000,
    B_DIVI  = 11'b00001000000,
    B_DIV   = 11'b00010000000,
    B_WRITE = 11'b00100000000,
    B_NEXT  = 11'b01000000000,
    B_DONE  = 11'b10000000000
  } bstate_t;

  bstate_t state;
  job_t    jq;
  logic [PIX_W-1:0]       px, py;
  logic [AW-1:0]          row_base, pix_addr, clr_cnt;
  logic signed [PW-1:0]   pr [6];
  logic [AREA_W-1:0]      wa, wb, wc;
  logic [2:0]             mac_k;
  logic signed [NUM_W-1:0] acc;
  logic [NW-1:0]          rem, dd;
  logic [ZW-1:0]          quo;
  logic [4:0]             step;
  logic [CNT_W-1:0]       count;
  logic                   res_valid;
  logic [COLOR_W-1:0]     res_color;
  logic [ZW-1:0]          res_depth;
  logic [CNT_W-1:0]       res_count;
  logic                   res_degen;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [RAM_W-1:0]       ram_wdata, ram_rdata;

  logic signed [SW-1:0]    sx, sy;
  logic signed [DW-1:0]    sxa, sxb, sxc, sya, syb, syc;
  logic signed [DIF_W-1:0] cyb, cxb, ayc, axc, bya, bxa;
  logic signed [EW-1:0]    ea_raw, eb_raw, ec_raw, ea, eb, ec;
  logic                    in_tri;
  logic [AREA_W-1:0]       wsel;
  logic signed [ZW-1:0]    zsel;
  logic [HALF_W-1:0]       half;
  logic signed [MW-1:0]    mprod;
  logic signed [NUM_W-1:0] term;
  logic signed [ZW-1:0]    znew, zold;
  logic                    nearer, rd_hit;

  rtri_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NPIX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  assign sx = $signed(SW'({px, 1'b1}) << SUBPIXEL_BITS);
  assign sy = $signed(SW'({py, 1'b1}) << SUBPIXEL_BITS);
  assign sxa = DW'(sx) - DW'(jq.ax);
  assign sxb = DW'(sx) - DW'(jq.bx);
  assign sxc = DW'(sx) - DW'(jq.cx);
  assign sya = DW'(sy) - DW'(jq.ay);
  assign syb = DW'(sy) - DW'(jq.by);
  assign syc = DW'(sy) - DW'(jq.cy);
  assign cyb = DIF_W'(jq.cy) - DIF_W'(jq.by);
  assign cxb = DIF_W'(jq.cx) - DIF_W'(jq.bx);
  assign ayc = DIF_W'(jq.ay) - DIF_W'(jq.cy);
  assign axc = DIF_W'(jq.ax) - DIF_W'(jq.cx);
  assign bya = DIF_W'(jq.by) - DIF_W'(jq.ay);
  assign bxa = DIF_W'(jq.bx) - DIF_W'(jq.ax);

  assign ea_raw = EW'(pr[0]) - EW'(pr[1]);
  assign eb_raw = EW'(pr[2]) - EW'(pr[3]);
  assign ec_raw = EW'(pr[4]) - EW'(pr[5]);
  assign ea = jq.neg ? -ea_raw : ea_raw;
  assign eb = jq.neg ? -eb_raw : eb_raw;
  assign ec = jq.neg ? -ec_raw : ec_raw;
  assign in_tri = !ea[EW-1] && !eb[EW-1] && !ec[EW-1];

  always_comb begin
    case (mac_k[2:1])
      2'd0: begin
        wsel = wa;
        zsel = jq.az;
      end
      2'd1: begin
        wsel = wb;
        zsel = jq.bz;
      end
      default: begin
        wsel = wc;
        zsel = jq.cz;
      end
    endcase
  end
  assign half  = mac_k[0] ? wsel[AREA_W-1:HALF_W] : wsel[HALF_W-1:0];
  assign mprod = $signed({1'b0, half}) * zsel;
  assign term  = mac_k[0] ? (NUM_W'(mprod) <<< HALF_W) : NUM_W'(mprod);

  assign znew   = $signed(quo ^ DEPTH_MIN);
  assign zold   = $signed(ram_rdata[ZW-1:0]);
  assign nearer = znew > zold;
  assign rd_hit = (jq.cmd == CMD_READ) && jq.rd_ok;

  assign ram_we    = (state == B_CLEAR) || (state == B_WRITE && nearer);
  assign ram_waddr = (state == B_CLEAR) ? clr_cnt : pix_addr;
  assign ram_wdata = (state == B_CLEAR) ? {jq.rgb, DEPTH_MIN} : {jq.rgb, znew};

  assign job_pop            = (state == B_IDLE) && job_valid;
  assign rsp.valid          = res_valid;
  assign rsp.read_color     = res_color;
  assign rsp.read_depth     = $signed(res_depth);
  assign rsp.pixels_written = res_count;
  assign rsp.degenerate     = res_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (state == B_DONE && (!res_valid || rsp.ready)) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_IDLE: if (job_valid) begin
          case (job.cmd)
            CMD_DRAW: begin
              if (job.degen || job.empty) begin
                state <= B_DONE;
              end else begin
                state <= B_EDGE;
              end
            end
            CMD_CLEAR: state <= B_CLEAR;
            CMD_READ:  state <= B_RD;
            default:   state <= B_DONE;
          endcase
        end
        B_CLEAR: if (clr_cnt == AW'(NPIX - 1)) begin
          state <= B_DONE;
        end
        B_RD:  state <= B_DONE;
        B_EDGE: state <= B_EDGE2;
        B_EDGE2: begin
          if (in_tri) begin
            state <= B_MAC;
          end else begin
            state <= B_NEXT;
          end
        end
        B_MAC: if (mac_k == 3'd5) begin
          state <= B_DIVI;
        end
        B_DIVI: state <= B_DIV;
        B_DIV: if (step == LAST_STEP) begin
          state <= B_WRITE;
        end
        B_WRITE: state <= B_NEXT;
        B_NEXT: begin
          if (px == jq.right && py == jq.bottom) begin
            state <= B_DONE;
          end else begin
            state <= B_EDGE;
          end
        end
        B_DONE: if (!res_valid || rsp.ready) begin
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: if (job_valid) begin
        jq       <= job;
        count    <= '0;
        clr_cnt  <= '0;
        px       <= job.left;
        py       <= job.top;
        row_base <= AW'(job.top) * AW'(FB_WIDTH);
        if (job.cmd == CMD_READ) begin
          pix_addr <= AW'(job.addr);
        end else begin
          pix_addr <= AW'(job.top) * AW'(FB_WIDTH) + AW'(job.left);
        end
      end
      B_CLEAR: clr_cnt <= clr_cnt + AW'(1);
      B_EDGE: begin
        pr[0] <= sxb * cyb;
        pr[1] <= syb * cxb;
        pr[2] <= sxc * ayc;
        pr[3] <= syc * axc;
        pr[4] <= sxa * bya;
        pr[5] <= sya * bxa;
      end
      B_EDGE2: begin
        wa    <= ea[AREA_W-1:0];
        wb    <= eb[AREA_W-1:0];
        wc    <= ec[AREA_W-1:0];
        mac_k <= 3'd0;
        acc   <= '0;
      end
      B_MAC: begin
        acc   <= acc + term;
        mac_k <= mac_k + 3'd1;
      end
      B_DIVI: begin
        rem  <= {acc, 1'b0} + NW'(jq.area) + NW'({jq.area, 24'b0});
        dd   <= NW'({jq.area, 24'b0});
        quo  <= '0;
        step <= '0;
      end
      B_DIV: begin
        if (rem >= dd) begin
          rem <= rem - dd;
          quo <= {quo[ZW-2:0], 1'b1};
        end else begin
          quo <= {quo[ZW-2:0], 1'b0};
        end
        dd   <= dd >> 1;
        step <= step + 5'd1;
      end
      B_WRITE: if (nearer) begin
        count <= count + CNT_W'(1);
      end
      B_NEXT: begin
        if (px == jq.right) begin
          px       <= jq.left;
          py       <= py + PIX_W'(1);
          row_base <= row_base + AW'(FB_WIDTH);
          pix_addr <= row_base + AW'(FB_WIDTH) + AW'(jq.left);
        end else begin
          px       <= px + PIX_W'(1);
          pix_addr <= pix_addr + AW'(1);
        end
      end
      B_DONE: if (!res_valid || rsp.ready) begin
        res_color <= rd_hit ? ram_rdata[RAM_W-1:ZW] : '0;
        res_depth <= rd_hit ? ram_rdata[ZW-1:0] : '0;
        res_count <= (jq.cmd == CMD_DRAW) ? count : '0;
        res_degen <= (jq.cmd == CMD_DRAW) && jq.degen;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/triangle_raster_zbuffer_unit.sv =====
// triangle rasterizer with color and depth store: top level
// draw: setup, then per scanned pixel an edge test; pixels inside the triangle also run
//   a 6-step depth mac and 24-step divider before the write; then the result is posted
// clear: one store write per cycle over all FB_WIDTH*FB_HEIGHT pixels; read: one store read
// front and back end are split by a 2-entry queue, so setup overlaps the previous request
// synchronous reset clears control and sets the full clip window; stores are not cleared
module triangle_raster_zbuffer_unit
  import rtri_pkg::*;
#(
  parameter int FB_WIDTH      = 1024,
  parameter int FB_HEIGHT     = 1024,
  parameter int SUBPIXEL_BITS = 4
) (
  input  logic              clk,
  input  logic              rst,
  rtri_req_if.sink          req,
  rtri_rsp_if.source        rsp,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CLIP_W-1:0] cfg_data
);
  clip_t clip;
  logic  push, full, pop, empty;
  job_t  push_job, pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip.left   <= '0;
      clip.top    <= '0;
      clip.right  <= CLIP_MAX;
      clip.bottom <= CLIP_MAX;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CLIP_LEFT:   clip.left   <= cfg_data;
        REG_CLIP_TOP:    clip.top    <= cfg_data;
        REG_CLIP_RIGHT:  clip.right  <= cfg_data;
        REG_CLIP_BOTTOM: clip.bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  rtri_front #(
    .FB_WIDTH      (FB_WIDTH),
    .FB_HEIGHT     (FB_HEIGHT),
    .SUBPIXEL_BITS (SUBPIXEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .clip     (clip),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  rtri_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  rtri_back #(
    .FB_WIDTH      (FB_WIDTH),
    .FB_HEIGHT     (FB_HEIGHT),
    .SUBPIXEL_BITS (SUBPIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!empty),
    .job       (pop_job),
    .job_pop   (pop),
    .rsp       (rsp)
  );
endmodule
